// ----- rtl/fwpi_pkg.sv -----
// ----------------------------------------------------------------------------
// fwpi_pkg
// Shared types and constants of the field-weakening PI controller: widths,
// register indexes, reset values, controller states and datapath commands.
// ----------------------------------------------------------------------------
package fwpi_pkg;

    // field widths
    localparam int VOLT_W   = 16;
    localparam int OUT_W    = 15;
    localparam int MAG_W    = 16;
    localparam int GAIN_W   = 15;
    localparam int CFG_W    = 16;
    localparam int CFG_IX_W = 3;

    // internal widths
    localparam int MUL_W    = 17;   // operand width, holds signed 16 and unsigned 15
    localparam int PROD_W   = 32;   // kept product bits
    localparam int RAD_W    = 32;   // d^2 + q^2
    localparam int REM_W    = 18;   // square-root partial remainder
    localparam int ERR_W    = 16;
    localparam int PROP_W   = 14;
    localparam int INTEG_W  = 21;
    localparam int SAT_W    = 17;
    localparam int INTEG_SUM_W = 33;
    localparam int SHIFT    = 7;
    localparam int SQRT_STEPS  = RAD_W / 2;
    localparam int CNT_W    = $clog2(SQRT_STEPS);

    localparam int S_TDATA_W = 2 * VOLT_W;
    localparam int M_TDATA_W = ((2 * OUT_W + MAG_W + 7) / 8) * 8;

    // register indexes
    localparam logic [CFG_IX_W-1:0] CFG_TARGET = 3'd0;
    localparam logic [CFG_IX_W-1:0] CFG_KP     = 3'd1;
    localparam logic [CFG_IX_W-1:0] CFG_KI     = 3'd2;
    localparam logic [CFG_IX_W-1:0] CFG_UPPER  = 3'd3;
    localparam logic [CFG_IX_W-1:0] CFG_LOWER  = 3'd4;

    localparam logic [MAG_W-1:0] TARGET_RESET = 16'd7992;   // 8192 - 200

    // clamp bounds
    localparam logic signed [17:0] ERR_MAX = 18'sd32767;
    localparam logic signed [17:0] ERR_MIN = -18'sd32768;
    localparam logic signed [24:0] PROP_MAX = 25'sd8191;
    localparam logic signed [24:0] PROP_MIN = -25'sd8192;
    localparam logic signed [INTEG_SUM_W-1:0] INTEG_MAX = 33'sd1048575;
    localparam logic signed [INTEG_SUM_W-1:0] INTEG_MIN = -33'sd1048576;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_D,
        ST_MUL_Q,
        ST_ADD_SQ,
        ST_SQRT,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_I,
        ST_INTEG,
        ST_SUM,
        ST_LIMIT,
        ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_DD,
        OP_MUL_QQ,
        OP_ADD_SQ,
        OP_SQRT,
        OP_ERR,
        OP_MUL_KP,
        OP_MUL_KI,
        OP_INTEG,
        OP_SUM,
        OP_LIMIT,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;   // result register full and not taken this cycle
    } t_dp_stat;

endpackage

// ----- rtl/fwpi_ctrl.sv -----
// ----------------------------------------------------------------------------
// fwpi_ctrl
// Sequencer: walks one item through squaring, the bit-pair square root,
// the gain multiplies, integration, limiting and the result register.
// ----------------------------------------------------------------------------
module fwpi_ctrl
    import fwpi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd.op   = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_MUL_D;
                end
            end
            ST_MUL_D: begin
                o_cmd.op = OP_MUL_DD;
                n_state  = ST_MUL_Q;
            end
            ST_MUL_Q: begin
                o_cmd.op = OP_MUL_QQ;
                n_state  = ST_ADD_SQ;
            end
            ST_ADD_SQ: begin
                o_cmd.op = OP_ADD_SQ;
                n_cnt    = CNT_W'(SQRT_STEPS - 1);
                n_state  = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (r_cnt == '0) begin
                    n_state = ST_ERR;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_ERR: begin
                o_cmd.op = OP_ERR;
                n_state  = ST_MUL_P;
            end
            ST_MUL_P: begin
                o_cmd.op = OP_MUL_KP;
                n_state  = ST_MUL_I;
            end
            ST_MUL_I: begin
                o_cmd.op = OP_MUL_KI;
                n_state  = ST_INTEG;
            end
            ST_INTEG: begin
                o_cmd.op = OP_INTEG;
                n_state  = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.op = OP_SUM;
                n_state  = ST_LIMIT;
            end
            ST_LIMIT: begin
                o_cmd.op = OP_LIMIT;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                // hold until the result register is free
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_OUT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/fwpi_dp.sv -----
// ----------------------------------------------------------------------------
// fwpi_dp
// Datapath: configuration registers, one shared 17x17 multiplier, a
// two-bits-per-cycle square root, integrator, clamps and result register.
// ----------------------------------------------------------------------------
module fwpi_dp
    import fwpi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [S_TDATA_W-1:0]  i_in_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [M_TDATA_W-1:0]  o_out_data
);

    // configuration
    logic        [MAG_W-1:0]   r_target;
    logic        [GAIN_W-1:0]  r_kp;
    logic        [GAIN_W-1:0]  r_ki;
    logic signed [OUT_W-1:0]   r_upper;
    logic signed [OUT_W-1:0]   r_lower;

    // controller state carried between items
    logic signed [INTEG_W-1:0] r_integ, n_integ;
    logic signed [SAT_W-1:0]   r_sat;
    logic                      r_out_valid;

    // per-item working registers
    logic signed [VOLT_W-1:0]  r_d;
    logic signed [VOLT_W-1:0]  r_q;
    logic signed [PROD_W-1:0]  r_prod;
    logic        [RAD_W-1:0]   r_rad;
    logic        [REM_W-1:0]   r_rem;
    logic        [MAG_W-1:0]   r_root;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [PROP_W-1:0]  r_prop;
    logic signed [OUT_W-1:0]   r_pi;
    logic signed [OUT_W-1:0]   r_lim;
    logic [M_TDATA_W-1:0]      r_out_data;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic        [REM_W+1:0]   rem_sh, trial, rem_diff;
    logic signed [17:0]        err_raw, err_c;
    logic signed [24:0]        prop_sh, prop_c;
    logic signed [INTEG_SUM_W-1:0] integ_sum;
    logic signed [OUT_W-1:0]   lim_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RESET;
            r_kp     <= '0;
            r_ki     <= '0;
            r_upper  <= '0;
            r_lower  <= '0;
        end else if (i_cfg_we) begin
            priority case (i_cfg_index)
                CFG_TARGET: r_target <= i_cfg_data;
                CFG_KP:     r_kp     <= i_cfg_data[GAIN_W-1:0];
                CFG_KI:     r_ki     <= i_cfg_data[GAIN_W-1:0];
                CFG_UPPER:  r_upper  <= i_cfg_data[OUT_W-1:0];
                CFG_LOWER:  r_lower  <= i_cfg_data[OUT_W-1:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_MUL_DD: begin
                mul_a = MUL_W'(r_d);
                mul_b = MUL_W'(r_d);
            end
            OP_MUL_QQ: begin
                mul_a = MUL_W'(r_q);
                mul_b = MUL_W'(r_q);
            end
            OP_MUL_KP: begin
                mul_a = MUL_W'(r_err);
                mul_b = $signed({2'b00, r_kp});
            end
            OP_MUL_KI: begin
                mul_a = MUL_W'(r_err);
                mul_b = $signed({2'b00, r_ki});
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // one root bit per cycle from the next two radicand bits
    assign rem_sh   = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign trial    = {2'b00, r_root, 2'b01};
    assign rem_diff = rem_sh - trial;

    assign err_raw = $signed({2'b00, r_target}) - $signed({2'b00, r_root});
    assign err_c   = (err_raw > ERR_MAX) ? ERR_MAX :
                     (err_raw < ERR_MIN) ? ERR_MIN : err_raw;

    assign prop_sh = 25'(r_prod >>> SHIFT);
    assign prop_c  = (prop_sh > PROP_MAX) ? PROP_MAX :
                     (prop_sh < PROP_MIN) ? PROP_MIN : prop_sh;

    assign integ_sum = INTEG_SUM_W'(r_integ) + INTEG_SUM_W'(r_prod)
                     + INTEG_SUM_W'($signed({r_sat, {SHIFT{1'b0}}}));

    always_comb begin
        if (r_ki == '0) begin
            n_integ = '0;
        end else if (integ_sum > INTEG_MAX) begin
            n_integ = INTEG_MAX[INTEG_W-1:0];
        end else if (integ_sum < INTEG_MIN) begin
            n_integ = INTEG_MIN[INTEG_W-1:0];
        end else begin
            n_integ = integ_sum[INTEG_W-1:0];
        end
    end

    // upper bound tested first; with inverted limits a value above the upper one gets it, any other gets the lower
    assign lim_c = (r_pi > r_upper) ? r_upper :
                   (r_pi < r_lower) ? r_lower : r_pi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ     <= '0;
            r_sat       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_INTEG) begin
                r_integ <= n_integ;
            end
            if (i_cmd.op == OP_OUT) begin
                r_sat       <= SAT_W'(r_lim) - SAT_W'(r_pi);
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_d <= i_in_data[VOLT_W-1:0];
                r_q <= i_in_data[2*VOLT_W-1:VOLT_W];
            end
            OP_MUL_DD: begin
                r_prod <= mul_p[PROD_W-1:0];
            end
            OP_MUL_QQ: begin
                r_prod <= mul_p[PROD_W-1:0];
                r_rad  <= r_prod;
            end
            OP_ADD_SQ: begin
                r_rad  <= r_rad + r_prod;
                r_rem  <= '0;
                r_root <= '0;
            end
            OP_SQRT: begin
                r_rad <= {r_rad[RAD_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem  <= rem_diff[REM_W-1:0];
                    r_root <= {r_root[MAG_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh[REM_W-1:0];
                    r_root <= {r_root[MAG_W-2:0], 1'b0};
                end
            end
            OP_ERR: begin
                r_err <= err_c[ERR_W-1:0];
            end
            OP_MUL_KP: begin
                r_prod <= mul_p[PROD_W-1:0];
            end
            OP_MUL_KI: begin
                r_prod <= mul_p[PROD_W-1:0];
                r_prop <= prop_c[PROP_W-1:0];
            end
            OP_SUM: begin
                r_pi <= OUT_W'(r_prop) + OUT_W'($signed(r_integ[INTEG_W-1:SHIFT]));
            end
            OP_LIMIT: begin
                r_lim <= lim_c;
            end
            OP_OUT: begin
                r_out_data <= M_TDATA_W'({r_root, r_pi, r_lim});
            end
            default: ;
        endcase
    end

    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;

endmodule

// ----- rtl/field_weakening_pi_controller.sv -----
// ----------------------------------------------------------------------------
// field_weakening_pi_controller
// Voltage-magnitude PI regulator with back-calculation anti-windup.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (i_s_*): one transfer carries volt_d and volt_q. The block
//   takes the floor square root of volt_d^2 + volt_q^2, regulates it toward
//   the target and returns one result transfer on the output stream (o_m_*)
//   with the clamped output, the unclamped PI sum and the magnitude.
//   Configuration: write i_cfg_data to register i_cfg_index while i_cfg_we
//   is high; 0 target, 1 Kp, 2 Ki, 3 upper limit, 4 lower limit. Write only
//   while no item is in flight.
//   Timing: one item at a time. The result becomes valid in the same cycle
//   that o_s_tready returns. The square root (two radicand bits a cycle)
//   and four passes through the one shared multiplier take up most of an
//   item's time.
//   Stall: the result sits in an output register; the next item is accepted
//   and computed while it waits, and holds before its final load until the
//   old result has been taken.
//   Reset: integrator and saturation excess clear, registers take their
//   reset values, both streams go idle.
// ----------------------------------------------------------------------------
module field_weakening_pi_controller
    import fwpi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,    // [15:0] volt_d, [31:16] volt_q
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,    // [14:0] limited_out,
                                                // [29:15] unlimited_out,
                                                // [45:30] voltage_magnitude,
                                                // [47:46] zero
    input  logic                  i_cfg_we,
    input  logic [CFG_IX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    fwpi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_stat     (stat),
        .o_in_ready (o_s_tready),
        .o_cmd      (cmd)
    );

    fwpi_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_s_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata)
    );

endmodule

// ----- rtl/fwpi_checker.sv -----
// ----------------------------------------------------------------------------
// fwpi_checker
// Port-level checks of the field-weakening PI controller, bound to the top.
// ----------------------------------------------------------------------------
module fwpi_checker
    import fwpi_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [S_TDATA_W-1:0]  i_s_tdata,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [M_TDATA_W-1:0]  o_m_tdata,
    input logic                  i_cfg_we,
    input logic [CFG_IX_W-1:0]   i_cfg_index,
    input logic [CFG_W-1:0]      i_cfg_data
);

    // reset empties both sides
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("streams not idle after reset");

    // one item at a time: input closes after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while an item is in work");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // magnitude of two 16-bit values never exceeds 46340, padding is zero
    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[45:30] <= 16'd46340 && o_m_tdata[47:46] == 2'b00)
        else $error("magnitude out of range");

endmodule

bind field_weakening_pi_controller fwpi_checker u_fwpi_checker (.*);
